### src/cicp_pkg.sv
package cicp_pkg;

  localparam int unsigned CHUNK_BYTES = 16;
  localparam int unsigned DATA_BYTES  = 4;
  localparam int unsigned QDEPTH      = 2;

  localparam logic [31:0] CRC_POLY = 32'hedb88320;
  localparam logic [31:0] CRC_INIT = 32'hffffffff;

  localparam logic [7:0] LEN_B3 = 8'h00;
  localparam logic [7:0] LEN_B0 = 8'h04;
  localparam logic [7:0] TYPE_C = 8'h63;
  localparam logic [7:0] TYPE_I = 8'h49;
  localparam logic [7:0] TYPE_CC = 8'h43;
  localparam logic [7:0] TYPE_P = 8'h50;

  typedef logic [7:0] byte_t;

  // one finished chunk: data bytes and the final crc
  typedef struct packed {
    byte_t [DATA_BYTES-1:0] data;
    logic [31:0]            crc;
  } chunk_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input byte_t b);
    logic [31:0] c;
    c = c_in ^ {24'h000000, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = CRC_POLY ^ (c >> 1);
      else c = c >> 1;
    end
    return c;
  endfunction

  // crc state after the four fixed type bytes
  localparam logic [31:0] CRC_TYPE =
    crc_byte(crc_byte(crc_byte(crc_byte(CRC_INIT, TYPE_C), TYPE_I), TYPE_CC), TYPE_P);

endpackage

### src/cicp_front.sv
module cicp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  cicp_pkg::byte_t      in_color_primaries,
  input  cicp_pkg::byte_t      in_transfer_function,
  input  cicp_pkg::byte_t      in_matrix_coefficients,
  input  cicp_pkg::byte_t      in_full_range_flag,
  input  cicp_pkg::qstat_t     qstat,
  output logic                 push,
  output cicp_pkg::chunk_t     push_data
);
  import cicp_pkg::*;

  byte_t [DATA_BYTES-1:0] data_r;
  logic [31:0] crc_r;
  logic [31:0] crc_nxt;
  logic [2:0]  cnt_r;
  logic        occ_r;
  logic        accept;
  logic        done;

  assign busy    = occ_r;
  assign accept  = start && !occ_r;
  assign done    = (cnt_r == 3'(DATA_BYTES));
  assign push    = occ_r && done && !qstat.full;
  assign crc_nxt = crc_byte(crc_r, data_r[cnt_r[1:0]]);

  assign push_data.data = data_r;
  assign push_data.crc  = crc_r ^ CRC_INIT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
      cnt_r <= '0;
    end else if (accept) begin
      occ_r <= 1'b1;
      cnt_r <= '0;
    end else if (push) begin
      occ_r <= 1'b0;
    end else if (occ_r && !done) begin
      cnt_r <= cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= {in_full_range_flag, in_matrix_coefficients,
                 in_transfer_function, in_color_primaries};
      crc_r  <= CRC_TYPE;
    end else if (occ_r && !done) begin
      crc_r <= crc_nxt;
    end
  end

endmodule

### src/cicp_queue.sv
module cicp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cicp_pkg::chunk_t  push_data,
  input  logic              pop,
  output cicp_pkg::chunk_t  head,
  output cicp_pkg::qstat_t  qstat
);
  import cicp_pkg::*;

  chunk_t mem [QDEPTH];
  logic [$clog2(QDEPTH)-1:0] wptr_r;
  logic [$clog2(QDEPTH)-1:0] rptr_r;
  logic [$clog2(QDEPTH):0]   count_r;

  assign qstat.full  = (count_r == ($clog2(QDEPTH)+1)'(QDEPTH));
  assign qstat.empty = (count_r == '0);
  assign head        = mem[rptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop) rptr_r <= rptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

### src/cicp_back.sv
module cicp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  cicp_pkg::chunk_t  head,
  input  cicp_pkg::qstat_t  qstat,
  output logic              pop,
  output logic              out_valid,
  output cicp_pkg::byte_t   out_chunk_byte,
  output logic              out_last_byte
);
  import cicp_pkg::*;

  chunk_t      cur_r;
  logic [3:0]  cnt_r;
  logic        act_r;
  logic        last;
  byte_t       sel;
  logic        valid_r;
  byte_t       byte_r;
  logic        last_r;

  assign last = (cnt_r == 4'(CHUNK_BYTES - 1));
  assign pop  = !qstat.empty && (!act_r || last);

  always_comb begin
    unique case (cnt_r)
      4'd0, 4'd1, 4'd2: sel = LEN_B3;
      4'd3:  sel = LEN_B0;
      4'd4:  sel = TYPE_C;
      4'd5:  sel = TYPE_I;
      4'd6:  sel = TYPE_CC;
      4'd7:  sel = TYPE_P;
      4'd8:  sel = cur_r.data[0];
      4'd9:  sel = cur_r.data[1];
      4'd10: sel = cur_r.data[2];
      4'd11: sel = cur_r.data[3];
      4'd12: sel = cur_r.crc[31:24];
      4'd13: sel = cur_r.crc[23:16];
      4'd14: sel = cur_r.crc[15:8];
      4'd15: sel = cur_r.crc[7:0];
      default: sel = LEN_B3;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= 1'b0;
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= act_r;
      if (pop) begin
        act_r <= 1'b1;
        cnt_r <= '0;
      end else if (act_r) begin
        if (last) act_r <= 1'b0;
        cnt_r <= cnt_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur_r <= head;
    byte_r <= sel;
    last_r <= last;
  end

  assign out_valid      = valid_r;
  assign out_chunk_byte = byte_r;
  assign out_last_byte  = last_r;

endmodule

### src/cicp_chunk_builder_crc32.sv
// cicp chunk builder with crc-32
// input: pulse start with the four code bytes on in_*; a transfer happens at a
// clock edge with start high and busy low. busy stays high while the front end
// folds the four data bytes into the crc (one byte per cycle) and until the
// finished chunk is placed in a two-entry queue.
// output: sixteen bytes per item, one per cycle, each marked by out_valid for
// exactly one cycle; out_last_byte flags the sixteenth (crc low) byte. the
// byte order is length 00 00 00 04, type c I C P, the four data bytes, then
// the crc most significant byte first.
// the byte-wide output stage sets the item rate; back-to-back chunks stream
// with no gap while the queue holds work.
// the receiver cannot stall: every byte is shown once and taken.
// reset (rst_n low, synchronous) empties the queue and drops any chunk in
// progress; no state is kept between items.
module cicp_chunk_builder_crc32 (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  cicp_pkg::byte_t  in_color_primaries,
  input  cicp_pkg::byte_t  in_transfer_function,
  input  cicp_pkg::byte_t  in_matrix_coefficients,
  input  cicp_pkg::byte_t  in_full_range_flag,
  output logic             out_valid,
  output cicp_pkg::byte_t  out_chunk_byte,
  output logic             out_last_byte
);
  import cicp_pkg::*;

  qstat_t qstat;
  logic   push;
  logic   pop;
  chunk_t push_data;
  chunk_t head;

  cicp_front u_front (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_color_primaries     (in_color_primaries),
    .in_transfer_function   (in_transfer_function),
    .in_matrix_coefficients (in_matrix_coefficients),
    .in_full_range_flag     (in_full_range_flag),
    .qstat                  (qstat),
    .push                   (push),
    .push_data              (push_data)
  );

  cicp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  cicp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .qstat          (qstat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_chunk_byte (out_chunk_byte),
    .out_last_byte  (out_last_byte)
  );

endmodule
